FILE: src/rgbhsv_pkg.sv
// ============================================================================
// rgbhsv_pkg: shared types, widths and helpers for the RGB to HSV converter
// Holds the pixel structs, the divider lane type and the one-bit divide step.
// ============================================================================
package rgbhsv_pkg;

    localparam int CompBits = 8;                  // width of one color component
    localparam int HueBits  = 15;                 // hue in 1/64 degree units
    localparam int SatBits  = 16;                 // saturation in Q0.16
    localparam int QuoBits  = 16;                 // quotient bits produced by the divider
    localparam int NumBits  = CompBits + QuoBits; // dividend width
    localparam int DivSteps = QuoBits;            // one quotient bit per pipeline stage
    localparam int AccBits  = NumBits + 2;        // signed width for the hue dividend

    localparam logic [HueBits-1:0] Hue60  = HueBits'(3840);
    localparam logic [HueBits-1:0] Hue0   = HueBits'(0);
    localparam logic [HueBits-1:0] Hue120 = HueBits'(7680);
    localparam logic [HueBits-1:0] Hue240 = HueBits'(15360);
    localparam logic [HueBits-1:0] Hue360 = HueBits'(23040);

    typedef struct packed {
        logic [CompBits-1:0] red;
        logic [CompBits-1:0] green;
        logic [CompBits-1:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic [HueBits-1:0]  hue;
        logic [SatBits-1:0]  saturation;
        logic [CompBits-1:0] value;
    } t_pix_out;

    // One division in flight. The partial remainder sits in rem; low holds the
    // dividend bits still to be consumed and, from the bottom, the quotient bits
    // already produced.
    typedef struct packed {
        logic [CompBits-1:0] rem;
        logic [QuoBits-1:0]  low;
        logic [CompBits-1:0] divisor;
    } t_div_lane;

    typedef struct packed {
        t_div_lane           sat;
        t_div_lane           hue;
        logic [CompBits-1:0] value;
        logic                gray;
    } t_div_item;

    // Restoring division, one quotient bit.
    function automatic t_div_lane div_step(input t_div_lane lane);
        logic [CompBits:0] trial;
        logic              qbit;
        t_div_lane         res;
        trial = {lane.rem, lane.low[QuoBits-1]};
        qbit  = (trial >= {1'b0, lane.divisor});
        res   = lane;
        if (qbit) begin
            res.rem = CompBits'(trial - {1'b0, lane.divisor});
        end else begin
            res.rem = trial[CompBits-1:0];
        end
        res.low = {lane.low[QuoBits-2:0], qbit};
        return res;
    endfunction

endpackage

FILE: src/rgbhsv_front.sv
// ============================================================================
// rgbhsv_front: extremes and dividends
// Two register stages: first the largest component, max minus min and the hue
// sector, then the saturation and hue dividends ready for the divider chain.
// ============================================================================
module rgbhsv_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  rgbhsv_pkg::t_pix_in   i_pixel,
    output logic                  o_valid,
    output rgbhsv_pkg::t_div_item o_item
);
    import rgbhsv_pkg::*;

    // Stage 1
    logic [CompBits-1:0] n_mx, n_mn, n_a, n_c;
    logic [HueBits-1:0]  n_base;
    logic [CompBits-1:0] r_mx, r_d, r_a, r_c;
    logic [HueBits-1:0]  r_base;
    logic                r_v1;

    // Stage 2
    logic [NumBits-1:0]        n_sat_num;
    logic signed [CompBits:0]  n_diff;
    logic [AccBits-1:0]        n_base_term;
    logic signed [AccBits-1:0] n_hue_acc;
    t_div_item                 n_item;
    t_div_item                 r_item;
    logic                      r_v2;

    always_comb begin
        n_mx = i_pixel.red;
        if (i_pixel.green > n_mx) n_mx = i_pixel.green;
        if (i_pixel.blue  > n_mx) n_mx = i_pixel.blue;
        n_mn = i_pixel.red;
        if (i_pixel.green < n_mn) n_mn = i_pixel.green;
        if (i_pixel.blue  < n_mn) n_mn = i_pixel.blue;

        // Ties go to red first, then green.
        priority if (i_pixel.red == n_mx) begin
            n_a    = i_pixel.green;
            n_c    = i_pixel.blue;
            n_base = (i_pixel.green >= i_pixel.blue) ? Hue0 : Hue360;
        end else if (i_pixel.green == n_mx) begin
            n_a    = i_pixel.blue;
            n_c    = i_pixel.red;
            n_base = Hue120;
        end else begin
            n_a    = i_pixel.red;
            n_c    = i_pixel.green;
            n_base = Hue240;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx   <= n_mx;
            r_d    <= n_mx - n_mn;
            r_a    <= n_a;
            r_c    <= n_c;
            r_base <= n_base;
        end
    end

    // The hue dividend is base*d + 60deg*(a - c); it is never negative, and
    // the quotient stays below 360 degrees, so 16 quotient bits are enough.
    always_comb begin
        n_sat_num   = NumBits'({r_d, QuoBits'(0)}) - NumBits'(r_d);
        n_diff      = $signed({1'b0, r_a}) - $signed({1'b0, r_c});
        n_base_term = AccBits'(r_base) * AccBits'(r_d);
        n_hue_acc   = $signed(n_base_term)
                    + $signed(AccBits'(Hue60)) * AccBits'(n_diff);

        n_item.sat.rem     = n_sat_num[NumBits-1 -: CompBits];
        n_item.sat.low     = n_sat_num[QuoBits-1:0];
        n_item.sat.divisor = r_mx;
        n_item.hue.rem     = n_hue_acc[NumBits-1 -: CompBits];
        n_item.hue.low     = n_hue_acc[QuoBits-1:0];
        n_item.hue.divisor = r_d;
        n_item.value       = r_mx;
        n_item.gray        = (r_d == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_v2;
    assign o_item  = r_item;

endmodule

FILE: src/rgbhsv_div_step.sv
// ============================================================================
// rgbhsv_div_step: one stage of the divider chain
// Produces one quotient bit for the saturation and the hue division.
// ============================================================================
module rgbhsv_div_step (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  rgbhsv_pkg::t_div_item i_item,
    output logic                  o_valid,
    output rgbhsv_pkg::t_div_item o_item
);
    import rgbhsv_pkg::*;

    t_div_item n_item;
    t_div_item r_item;
    logic      r_valid;

    always_comb begin
        n_item     = i_item;
        n_item.sat = div_step(i_item.sat);
        n_item.hue = div_step(i_item.hue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: src/rgb_to_hsv_converter_core.sv
// An accepted request passes the front stages and then the divider chain, one
// quotient bit per stage.
// Throughput: one pixel per cycle; the whole pipeline holds while a result
// waits on o_valid with i_stall high.
// Reset (synchronous, active low) clears all stage valid bits; data is not reset.
// ============================================================================
// rgb_to_hsv_converter_core: pipelined RGB to HSV pixel converter
// Front stages find the extremes and dividends; a chain of divide stages
// forms saturation and hue; the last stage register drives the output.
// ============================================================================
module rgb_to_hsv_converter_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  rgbhsv_pkg::t_pix_in  i_pixel,
    output logic                 o_valid,
    input  logic                 i_stall,
    output rgbhsv_pkg::t_pix_out o_pixel
);
    import rgbhsv_pkg::*;

    logic      en;
    logic      stage_valid [DivSteps+1];
    t_div_item stage_item  [DivSteps+1];
    t_div_item last_item;

    // Every stage moves together unless the finished result is being held.
    assign en      = !(stage_valid[DivSteps] && i_stall);
    assign o_stall = !en;

    rgbhsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_pixel (i_pixel),
        .o_valid (stage_valid[0]),
        .o_item  (stage_item[0])
    );

    for (genvar s = 0; s < DivSteps; s++) begin : g_div
        rgbhsv_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (stage_valid[s]),
            .i_item  (stage_item[s]),
            .o_valid (stage_valid[s+1]),
            .o_item  (stage_item[s+1])
        );
    end

    assign last_item = stage_item[DivSteps];
    assign o_valid   = stage_valid[DivSteps];

    // Gray pixels have no defined hue; both divisions are overridden with zero.
    always_comb begin
        o_pixel.value = last_item.value;
        if (last_item.gray) begin
            o_pixel.hue        = '0;
            o_pixel.saturation = '0;
        end else begin
            o_pixel.hue        = last_item.hue.low[HueBits-1:0];
            o_pixel.saturation = last_item.sat.low[SatBits-1:0];
        end
    end

endmodule
